// File: sv/pps_pkg.sv
`default_nettype none

package pps_pkg;

    // Datapath widths
    localparam int AW     = 34;   // atan operands, sine, quaternion products
    localparam int CW     = 45;   // CORDIC x and y
    localparam int ZW     = 34;   // CORDIC angle accumulator
    localparam int MW     = 33;   // shared multiplier operand
    localparam int CNT_W  = 5;    // step counter
    localparam int SQ_W   = 62;   // square root radicand, root and bit
    localparam int DIST_W = 34;   // distance in position LSBs
    localparam int RM_W   = 56;   // divider remainder
    localparam int DV_W   = 75;   // divider shifted divisor
    localparam int QW     = 25;   // quotient bits
    localparam int SFT_W  = 2;    // distance prescale count
    localparam int OUT_W  = 24;
    localparam int CFG_W  = 19;
    localparam int MODE_W = 3;

    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    localparam logic signed [CW-1:0] SIN_START   = CW'(652032874);
    localparam logic signed [CW-1:0] NORM_COARSE = CW'(64'h0000_0002_0000_0000);
    localparam logic signed [CW-1:0] NORM_FINE   = CW'(64'h0000_0100_0000_0000);
    localparam logic signed [AW-1:0] STOP_POS    = AW'(6553600);
    localparam logic signed [AW-1:0] YAW_ONE     = AW'(64'h1000_0000);
    localparam logic [AW-1:0]        DIST_LIMIT  = AW'(64'h4000_0000);
    localparam logic [SQ_W-1:0]      SQRT_TOP    = SQ_W'(64'h1000_0000_0000_0000);
    localparam logic [CNT_W-1:0]     SQRT_LAST   = CNT_W'(30);
    localparam logic [CNT_W-1:0]     DIV_TOP     = CNT_W'(24);
    localparam int                   DIV_SHIFT   = 39;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;
    localparam logic [QW-1:0]           SAT_POS = 25'd8388607;
    localparam logic [QW-1:0]           SAT_NEG = 25'd8388608;

    localparam logic [CFG_W-1:0]        SPEED_RST = 19'd6554;
    localparam logic [CFG_W-1:0]        SPIN_RST  = 19'd13107;
    localparam logic signed [OUT_W-1:0] ANG_RST   = 24'sd10774;
    localparam int                      TGT_X_RST = 22938;
    localparam int                      TGT_Y_RST = 16384;

    // Drive modes
    localparam logic [MODE_W-1:0] MODE_PURSUE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RIGHT_A = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LEFT_A  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LEFT_B  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RIGHT_B = 3'd4;

    // Register indexes (address bit 2)
    localparam logic REG_SPEED = 1'b0;
    localparam logic REG_SPIN  = 1'b1;

    // Binary-angle arctangent of 2^-i
    function automatic logic [31:0] atan_entry(input logic [CNT_W-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: sv/pure_pursuit_steering.sv
// Channel   Direction  Transfer                 Contents
// s_*       in         s_tvalid & s_tready      pose update or goal update (s_tuser = cmd)
// m_*       out        m_tvalid & m_tready      drive command, one per pose update
// APB       in         psel & penable & pwrite  linear_speed at 0x0, spin_rate at 0x4
//
// A goal update gives no result and leaves the block idle. Stop, creep and
// hold pose updates go straight to the output state. A pursuit update runs
// two vectoring passes, each after normalize steps, and one rotation pass
// through the shared CORDIC stage, 31 steps of the bit-pair square root and
// 25 steps of the bit-serial divider, with every product on one shared
// multiplier. A zero yaw or bearing vector, a zero distance or a saturating
// quotient skips the matching steps.
// Reset is synchronous on aresetn low. s_tready is high only between items; a
// result waiting on m_tready holds in its output register while the next item
// is taken, and a finished item stalls there only if that register is full.

`default_nettype none

module pure_pursuit_steering #(
    parameter int POS_WIDTH    = 24,
    parameter int CORDIC_STEPS = 16
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  wire                                      s_tvalid,
    output logic                                     s_tready,
    // pos_x, pos_y, quat_z, quat_w, goal_x, goal_y, goal_mode, zero fill
    input  wire  [8*((4*POS_WIDTH+35+7)/8)-1:0]      s_tdata,
    // cmd
    input  wire                                      s_tuser,
    output logic                                     m_tvalid,
    input  wire                                      m_tready,
    // linear_x, angular_z
    output logic [2*pps_pkg::OUT_W-1:0]              m_tdata,
    input  wire                                      psel,
    input  wire                                      penable,
    input  wire                                      pwrite,
    input  wire  [2:0]                               paddr,
    input  wire  [31:0]                              pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    import pps_pkg::*;

    localparam int OFF_PY = POS_WIDTH;
    localparam int OFF_QZ = 2*POS_WIDTH;
    localparam int OFF_QW = 2*POS_WIDTH + 16;
    localparam int OFF_GX = 2*POS_WIDTH + 32;
    localparam int OFF_GY = 3*POS_WIDTH + 32;
    localparam int OFF_MD = 4*POS_WIDTH + 32;
    localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STEPS - 1);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_MNUM   = 5'd1;
    localparam logic [4:0] ST_MDEN   = 5'd2;
    localparam logic [4:0] ST_ALOAD  = 5'd3;
    localparam logic [4:0] ST_NORM   = 5'd4;
    localparam logic [4:0] ST_CORD   = 5'd5;
    localparam logic [4:0] ST_AFIX   = 5'd6;
    localparam logic [4:0] ST_DLOAD  = 5'd7;
    localparam logic [4:0] ST_DSHIFT = 5'd8;
    localparam logic [4:0] ST_SQX    = 5'd9;
    localparam logic [4:0] ST_SQY    = 5'd10;
    localparam logic [4:0] ST_SQRT   = 5'd11;
    localparam logic [4:0] ST_DIST   = 5'd12;
    localparam logic [4:0] ST_TOP    = 5'd13;
    localparam logic [4:0] ST_DCHK   = 5'd14;
    localparam logic [4:0] ST_DIV    = 5'd15;
    localparam logic [4:0] ST_DFIN   = 5'd16;
    localparam logic [4:0] ST_OUT    = 5'd17;

    // Control and held state
    logic [4:0]               state_reg;
    logic [CFG_W-1:0]         speed_reg, spin_reg;
    logic signed [POS_WIDTH-1:0] tgt_x_reg, tgt_y_reg;
    logic [MODE_W-1:0]        mode_reg;
    logic signed [OUT_W-1:0]  held_lin_reg, held_ang_reg;
    logic                     m_valid_reg;

    // Datapath
    logic signed [15:0]       qz_reg, qw_reg;
    logic signed [AW-1:0]     dx_reg, dy_reg, num_reg, den_reg, sine_reg;
    logic                     phase_reg, vec_reg, xneg_reg, yneg_reg;
    logic signed [CW-1:0]     cx_reg, cy_reg;
    logic signed [ZW-1:0]     cz_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [31:0]              yaw_reg;
    logic [AW-1:0]            ax_reg, ay_reg;
    logic [SFT_W-1:0]         sft_reg;
    logic [SQ_W-1:0]          sq_reg, root_reg, bit_reg;
    logic [DIST_W-1:0]        dist_reg;
    logic [RM_W-1:0]          rem_reg;
    logic [DV_W-1:0]          dvs_reg;
    logic [QW-1:0]            quo_reg;
    logic [OUT_W-1:0]         m_lin_reg, m_ang_reg;

    // Input fields
    logic signed [POS_WIDTH-1:0] in_pos_x, in_pos_y, in_goal_x, in_goal_y;
    logic signed [15:0]          in_quat_z, in_quat_w;
    logic [MODE_W-1:0]           in_goal_mode;
    logic                        in_xfer, cfg_wr, is_stop;
    logic signed [AW-1:0]        tgt_x_ext, tgt_y_ext;

    assign in_pos_x     = s_tdata[0 +: POS_WIDTH];
    assign in_pos_y     = s_tdata[OFF_PY +: POS_WIDTH];
    assign in_quat_z    = s_tdata[OFF_QZ +: 16];
    assign in_quat_w    = s_tdata[OFF_QW +: 16];
    assign in_goal_x    = s_tdata[OFF_GX +: POS_WIDTH];
    assign in_goal_y    = s_tdata[OFF_GY +: POS_WIDTH];
    assign in_goal_mode = s_tdata[OFF_MD +: MODE_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;

    assign tgt_x_ext = {{(AW-POS_WIDTH){tgt_x_reg[POS_WIDTH-1]}}, tgt_x_reg};
    assign tgt_y_ext = {{(AW-POS_WIDTH){tgt_y_reg[POS_WIDTH-1]}}, tgt_y_reg};
    assign is_stop   = (tgt_x_ext == STOP_POS) && (tgt_y_ext == STOP_POS);

    // Register read
    always_comb begin
        unique case (paddr[2])
            REG_SPEED: prdata = {{(32-CFG_W){1'b0}}, speed_reg};
            REG_SPIN:  prdata = {{(32-CFG_W){1'b0}}, spin_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // Shared multiplier
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] mul_p;
    logic [AW-1:0]          sine_mag;

    assign sine_mag = sine_reg[AW-1] ? AW'(-sine_reg) : AW'(sine_reg);

    always_comb begin
        case (state_reg)
            ST_MNUM: begin
                mul_a = {{(MW-16){qw_reg[15]}}, qw_reg};
                mul_b = {{(MW-16){qz_reg[15]}}, qz_reg};
            end
            ST_MDEN: begin
                mul_a = {{(MW-16){qz_reg[15]}}, qz_reg};
                mul_b = {{(MW-16){qz_reg[15]}}, qz_reg};
            end
            ST_SQX: begin
                mul_a = {1'b0, ax_reg[MW-2:0]};
                mul_b = {1'b0, ax_reg[MW-2:0]};
            end
            ST_SQY: begin
                mul_a = {1'b0, ay_reg[MW-2:0]};
                mul_b = {1'b0, ay_reg[MW-2:0]};
            end
            ST_TOP: begin
                mul_a = {{(MW-CFG_W){1'b0}}, speed_reg};
                mul_b = {1'b0, sine_mag[MW-2:0]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Atan operand select and magnitudes
    logic signed [AW-1:0] x_op, y_op;
    logic [AW-1:0]        x_mag, y_mag, dx_mag, dy_mag;

    assign x_op   = phase_reg ? dx_reg : den_reg;
    assign y_op   = phase_reg ? dy_reg : num_reg;
    assign x_mag  = x_op[AW-1] ? AW'(-x_op) : AW'(x_op);
    assign y_mag  = y_op[AW-1] ? AW'(-y_op) : AW'(y_op);
    assign dx_mag = dx_reg[AW-1] ? AW'(-dx_reg) : AW'(dx_reg);
    assign dy_mag = dy_reg[AW-1] ? AW'(-dy_reg) : AW'(dy_reg);

    // CORDIC stage, shared by vectoring and rotation
    logic signed [CW-1:0] x_sh, y_sh, c_max, cx_next, cy_next;
    logic signed [ZW-1:0] at_ext, cz_next;
    logic                 dir_pos;

    assign x_sh    = cx_reg >>> cnt_reg;
    assign y_sh    = cy_reg >>> cnt_reg;
    assign at_ext  = {{(ZW-32){1'b0}}, atan_entry(cnt_reg)};
    assign dir_pos = vec_reg ? !(cy_reg > 0) : !cz_reg[ZW-1];
    assign cx_next = dir_pos ? cx_reg - y_sh : cx_reg + y_sh;
    assign cy_next = dir_pos ? cy_reg + x_sh : cy_reg - x_sh;
    assign cz_next = dir_pos ? cz_reg - at_ext : cz_reg + at_ext;
    assign c_max   = (cx_reg > cy_reg) ? cx_reg : cy_reg;

    // Quadrant fix and sine argument fold
    logic [31:0] zc, ang, diff, sin_arg, diff_q;

    assign zc = cz_reg[31:0];
    always_comb begin
        if (!xneg_reg && !yneg_reg) begin
            ang = zc;
        end else if (xneg_reg && !yneg_reg) begin
            ang = HALF_TURN - zc;
        end else if (xneg_reg) begin
            ang = HALF_TURN + zc;
        end else begin
            ang = 32'd0 - zc;
        end
    end
    assign diff    = ang - yaw_reg;
    assign diff_q  = diff + QUARTER_TURN;
    assign sin_arg = diff_q[31] ? HALF_TURN - diff : diff;

    // Square root step, distance, divider compare
    logic [SQ_W-1:0]   sq_trial;
    logic [DIST_W-1:0] dist_val;
    logic              div_ge, div_ovf;
    logic [QW-1:0]     quo_neg;

    assign sq_trial = root_reg + bit_reg;
    assign dist_val = DIST_W'(root_reg[30:0]) << sft_reg;
    assign div_ge   = (DV_W'(rem_reg) >= dvs_reg);
    assign div_ovf  = (DV_W'(rem_reg) >= {dvs_reg[DV_W-2:0], 1'b0});
    assign quo_neg  = QW'(0) - quo_reg;

    // Sequencer and held command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            speed_reg    <= SPEED_RST;
            spin_reg     <= SPIN_RST;
            tgt_x_reg    <= POS_WIDTH'(TGT_X_RST);
            tgt_y_reg    <= POS_WIDTH'(TGT_Y_RST);
            mode_reg     <= MODE_PURSUE;
            held_lin_reg <= '0;
            held_ang_reg <= ANG_RST;
            m_valid_reg  <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_SPEED: speed_reg <= pwdata[CFG_W-1:0];
                    REG_SPIN:  spin_reg  <= pwdata[CFG_W-1:0];
                    default:   speed_reg <= speed_reg;
                endcase
            end

            // drop result after its transfer, load a new one from ST_OUT
            if (state_reg == ST_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (s_tuser) begin
                            tgt_x_reg <= in_goal_x;
                            tgt_y_reg <= in_goal_y;
                            mode_reg  <= in_goal_mode;
                        end else if (is_stop) begin
                            held_lin_reg <= '0;
                            held_ang_reg <= '0;
                            state_reg    <= ST_OUT;
                        end else begin
                            unique case (mode_reg) inside
                                MODE_PURSUE: begin
                                    held_lin_reg <= OUT_W'(speed_reg);
                                    state_reg    <= ST_MNUM;
                                end
                                MODE_RIGHT_A, MODE_RIGHT_B: begin
                                    held_lin_reg <= OUT_W'(1);
                                    held_ang_reg <= OUT_W'(0) - OUT_W'(spin_reg);
                                    state_reg    <= ST_OUT;
                                end
                                MODE_LEFT_A, MODE_LEFT_B: begin
                                    held_lin_reg <= OUT_W'(1);
                                    held_ang_reg <= OUT_W'(spin_reg);
                                    state_reg    <= ST_OUT;
                                end
                                default: begin
                                    state_reg <= ST_OUT;
                                end
                            endcase
                        end
                    end
                end
                ST_MNUM:   state_reg <= ST_MDEN;
                ST_MDEN:   state_reg <= ST_ALOAD;
                ST_ALOAD: begin
                    if (x_mag == '0 && y_mag == '0) begin
                        state_reg <= ST_AFIX;
                    end else begin
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if (c_max >= NORM_FINE) begin
                        state_reg <= ST_CORD;
                    end
                end
                ST_CORD: begin
                    if (cnt_reg == CORD_LAST) begin
                        state_reg <= vec_reg ? ST_AFIX : ST_DLOAD;
                    end
                end
                ST_AFIX: begin
                    state_reg <= phase_reg ? ST_CORD : ST_ALOAD;
                end
                ST_DLOAD:  state_reg <= ST_DSHIFT;
                ST_DSHIFT: begin
                    if (ax_reg < DIST_LIMIT && ay_reg < DIST_LIMIT) begin
                        state_reg <= ST_SQX;
                    end
                end
                ST_SQX:    state_reg <= ST_SQY;
                ST_SQY:    state_reg <= ST_SQRT;
                ST_SQRT: begin
                    if (cnt_reg == '0) begin
                        state_reg <= ST_DIST;
                    end
                end
                ST_DIST: begin
                    // zero distance: saturate toward the sign of the sine, zero for a zero sine
                    if (dist_val == '0) begin
                        if (sine_reg > 0) begin
                            held_ang_reg <= OUT_MAX;
                        end else if (sine_reg < 0) begin
                            held_ang_reg <= OUT_MIN;
                        end else begin
                            held_ang_reg <= '0;
                        end
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_TOP;
                    end
                end
                ST_TOP:    state_reg <= ST_DCHK;
                ST_DCHK: begin
                    if (div_ovf) begin
                        held_ang_reg <= sine_reg[AW-1] ? OUT_MIN : OUT_MAX;
                        state_reg    <= ST_OUT;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == '0) begin
                        state_reg <= ST_DFIN;
                    end
                end
                ST_DFIN: begin
                    if (!sine_reg[AW-1]) begin
                        held_ang_reg <= (quo_reg > SAT_POS) ? OUT_MAX : OUT_W'(quo_reg);
                    end else begin
                        held_ang_reg <= (quo_reg > SAT_NEG) ? OUT_MIN : OUT_W'(quo_neg);
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                qz_reg    <= in_quat_z;
                qw_reg    <= in_quat_w;
                dx_reg    <= tgt_x_ext - {{(AW-POS_WIDTH){in_pos_x[POS_WIDTH-1]}}, in_pos_x};
                dy_reg    <= tgt_y_ext - {{(AW-POS_WIDTH){in_pos_y[POS_WIDTH-1]}}, in_pos_y};
                phase_reg <= 1'b0;
            end
            ST_MNUM: begin
                num_reg <= {mul_p[AW-2:0], 1'b0};
            end
            ST_MDEN: begin
                den_reg <= YAW_ONE - {mul_p[AW-2:0], 1'b0};
            end
            ST_ALOAD: begin
                cx_reg   <= {{(CW-AW){1'b0}}, x_mag};
                cy_reg   <= {{(CW-AW){1'b0}}, y_mag};
                cz_reg   <= '0;
                xneg_reg <= x_op[AW-1];
                yneg_reg <= y_op[AW-1];
                cnt_reg  <= '0;
                vec_reg  <= 1'b1;
            end
            ST_NORM: begin
                // bring the larger magnitude up to [2^40, 2^41)
                if (c_max < NORM_COARSE) begin
                    cx_reg <= cx_reg <<< 8;
                    cy_reg <= cy_reg <<< 8;
                end else if (c_max < NORM_FINE) begin
                    cx_reg <= cx_reg <<< 1;
                    cy_reg <= cy_reg <<< 1;
                end
            end
            ST_CORD: begin
                cx_reg  <= cx_next;
                cy_reg  <= cy_next;
                cz_reg  <= cz_next;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            ST_AFIX: begin
                if (!phase_reg) begin
                    yaw_reg   <= ang;
                    phase_reg <= 1'b1;
                end else begin
                    // rotate the unit vector by the bearing error
                    cx_reg  <= SIN_START;
                    cy_reg  <= '0;
                    cz_reg  <= {{(ZW-32){sin_arg[31]}}, sin_arg};
                    cnt_reg <= '0;
                    vec_reg <= 1'b0;
                end
            end
            ST_DLOAD: begin
                sine_reg <= cy_reg[AW-1:0];
                ax_reg   <= dx_mag;
                ay_reg   <= dy_mag;
                sft_reg  <= '0;
            end
            ST_DSHIFT: begin
                if (ax_reg >= DIST_LIMIT || ay_reg >= DIST_LIMIT) begin
                    ax_reg  <= ax_reg >> 1;
                    ay_reg  <= ay_reg >> 1;
                    sft_reg <= sft_reg + SFT_W'(1);
                end
            end
            ST_SQX: begin
                sq_reg <= {2'b00, mul_p[SQ_W-3:0]};
            end
            ST_SQY: begin
                sq_reg   <= sq_reg + {2'b00, mul_p[SQ_W-3:0]};
                root_reg <= '0;
                bit_reg  <= SQRT_TOP;
                cnt_reg  <= SQRT_LAST;
            end
            ST_SQRT: begin
                if (sq_reg >= sq_trial) begin
                    sq_reg   <= sq_reg - sq_trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            ST_DIST: begin
                dist_reg <= dist_val;
            end
            ST_TOP: begin
                // numerator 4*v*|sin| + dist*2^14, divisor dist*2^15 aligned to bit 24
                rem_reg <= (RM_W'(mul_p[RM_W-3:0]) << 2) + (RM_W'(dist_reg) << 14);
                dvs_reg <= DV_W'(dist_reg) << DIV_SHIFT;
            end
            ST_DCHK: begin
                cnt_reg <= DIV_TOP;
                quo_reg <= '0;
            end
            ST_DIV: begin
                if (div_ge) begin
                    rem_reg <= rem_reg - dvs_reg[RM_W-1:0];
                end
                quo_reg <= {quo_reg[QW-2:0], div_ge};
                dvs_reg <= dvs_reg >> 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_lin_reg <= held_lin_reg;
                    m_ang_reg <= held_ang_reg;
                end
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_ang_reg, m_lin_reg};

    // Checks
    a_goal_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> (state_reg == ST_IDLE))
        else $error("goal transfer left the idle state");

    a_out_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_valid_reg || m_tready)) |=> m_valid_reg)
        else $error("finished command not presented");

    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (DV_W'(rem_reg) < {dvs_reg[DV_W-2:0], 1'b0}))
        else $error("divider remainder out of range");

    a_cord_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORD) |-> (cnt_reg <= CORD_LAST))
        else $error("CORDIC step count overrun");

endmodule

`default_nettype wire
